FILE: rtl/tile_dark_channel_assert.svh
// Assertion macros shared by the tile dark channel RTL.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef TILE_DARK_CHANNEL_ASSERT_SVH
`define TILE_DARK_CHANNEL_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define TDC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tdc_pkg.sv
// Package for the tile dark channel block: limits, field widths, payload types
// and configuration register indexes. No dependencies.
`default_nettype none

package tdc_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int MAX_TILE   = 64;

  localparam int POS_W  = 11;
  localparam int OFS_W  = $clog2(MAX_TILE);
  localparam int TSZ_W  = 7;
  localparam int FRM_W  = 12;
  localparam int CFG_W  = 12;
  localparam int CIDX_W = 2;
  localparam int PIX_W  = 8;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef enum logic [CIDX_W-1:0] {
    CFG_TILE_SIZE    = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [POS_W-1:0] tile_column;
    logic [POS_W-1:0] tile_row;
    logic [PIX_W-1:0] min_value;
    logic             frame_last;
  } tile_result_t;

endpackage

`default_nettype wire

FILE: rtl/tile_dark_channel.sv
// Top level of the tile dark channel block: pixel counters, column minima
// memory with read-modify-write and forwarding, and the result queue.
// Depends on tdc_pkg and tile_dark_channel_assert.svh.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   tdc_pkg::pixel_t
//   out_     output     out_valid / out_stall tdc_pkg::tile_result_t
//   cfg_     input      cfg_wr_en             cfg_index, cfg_wdata
//
// One pixel is taken every clock while in_stall is low; a tile result enters the queue from the update stage.
// The column minima memory is read when a pixel is taken and written in the next cycle;
// a read of the entry being written gets the new value forwarded.
// Reset clears counters and the queue; the memory needs no clearing pass.
// in_stall rises when the four-entry result queue is full, or holds three entries while an update is in flight.
`default_nettype none

module tile_dark_channel (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  tdc_pkg::pixel_t            in_data,
  output logic                       out_valid,
  input  wire                        out_stall,
  output tdc_pkg::tile_result_t      out_data,
  input  wire                        cfg_wr_en,
  input  wire [tdc_pkg::CIDX_W-1:0]  cfg_index,
  input  wire [tdc_pkg::CFG_W-1:0]   cfg_wdata
);
  import tdc_pkg::*;
  `include "tile_dark_channel_assert.svh"

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  logic [TSZ_W-1:0] tile_size_r;
  logic [FRM_W-1:0] frame_width_r;
  logic [FRM_W-1:0] frame_height_r;

  logic [POS_W-1:0] pixel_x_r, pixel_x_nxt;
  logic [POS_W-1:0] pixel_y_r, pixel_y_nxt;
  logic [OFS_W-1:0] ofs_x_r, ofs_x_nxt;
  logic [OFS_W-1:0] ofs_y_r, ofs_y_nxt;
  logic [POS_W-1:0] tile_col_r, tile_col_nxt;
  logic [POS_W-1:0] tile_row_r, tile_row_nxt;

  logic [OFS_W-1:0] tile_m1;
  logic [POS_W-1:0] width_m1;
  logic [POS_W-1:0] height_m1;
  logic             row_end, col_end, tile_x_end, tile_y_end;
  logic             accept;
  logic [PIX_W-1:0] pix_min;

  logic [PIX_W-1:0] col_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_data_r;

  logic             s1_valid_r;
  logic [POS_W-1:0] s1_addr_r;
  logic             s1_start_r;
  logic             s1_emit_r;
  logic             s1_last_r;
  logic [POS_W-1:0] s1_row_r;
  logic [PIX_W-1:0] s1_min_r;
  logic             fwd_r;
  logic [PIX_W-1:0] fwd_data_r;
  logic [PIX_W-1:0] s1_prev;
  logic [PIX_W-1:0] s1_acc;

  tile_result_t      queue_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] q_cnt_r;
  logic              q_push, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r    <= TSZ_W'(15);
      frame_width_r  <= FRM_W'(640);
      frame_height_r <= FRM_W'(480);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TILE_SIZE:    tile_size_r    <= cfg_wdata[TSZ_W-1:0];
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FRM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FRM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tile_size_r == '0) begin
      tile_m1 = '0;
    end else if (tile_size_r > TSZ_W'(MAX_TILE)) begin
      tile_m1 = OFS_W'(MAX_TILE - 1);
    end else begin
      tile_m1 = OFS_W'(tile_size_r - TSZ_W'(1));
    end
    if (frame_width_r == '0) begin
      width_m1 = '0;
    end else if (frame_width_r > FRM_W'(MAX_WIDTH)) begin
      width_m1 = POS_W'(MAX_WIDTH - 1);
    end else begin
      width_m1 = POS_W'(frame_width_r - FRM_W'(1));
    end
    if (frame_height_r == '0) begin
      height_m1 = '0;
    end else if (frame_height_r > FRM_W'(MAX_HEIGHT)) begin
      height_m1 = POS_W'(MAX_HEIGHT - 1);
    end else begin
      height_m1 = POS_W'(frame_height_r - FRM_W'(1));
    end
  end

  assign row_end    = pixel_x_r >= width_m1;
  assign col_end    = pixel_y_r >= height_m1;
  assign tile_x_end = row_end || (ofs_x_r >= tile_m1);
  assign tile_y_end = col_end || (ofs_y_r >= tile_m1);

  assign in_stall = (q_cnt_r == QCNT_W'(QDEPTH)) ||
                    ((q_cnt_r == QCNT_W'(QDEPTH - 1)) && s1_valid_r);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pix_min = (in_data.red < in_data.green) ? in_data.red : in_data.green;
    if (in_data.blue < pix_min) begin
      pix_min = in_data.blue;
    end
  end

  always_comb begin
    pixel_x_nxt  = pixel_x_r;
    pixel_y_nxt  = pixel_y_r;
    ofs_x_nxt    = ofs_x_r;
    ofs_y_nxt    = ofs_y_r;
    tile_col_nxt = tile_col_r;
    tile_row_nxt = tile_row_r;
    if (accept) begin
      if (row_end) begin
        pixel_x_nxt  = '0;
        ofs_x_nxt    = '0;
        tile_col_nxt = '0;
        if (col_end) begin
          pixel_y_nxt  = '0;
          ofs_y_nxt    = '0;
          tile_row_nxt = '0;
        end else begin
          pixel_y_nxt = pixel_y_r + POS_W'(1);
          if (tile_y_end) begin
            ofs_y_nxt    = '0;
            tile_row_nxt = tile_row_r + POS_W'(1);
          end else begin
            ofs_y_nxt = ofs_y_r + OFS_W'(1);
          end
        end
      end else begin
        pixel_x_nxt = pixel_x_r + POS_W'(1);
        if (tile_x_end) begin
          ofs_x_nxt    = '0;
          tile_col_nxt = tile_col_r + POS_W'(1);
        end else begin
          ofs_x_nxt = ofs_x_r + OFS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_x_r  <= '0;
      pixel_y_r  <= '0;
      ofs_x_r    <= '0;
      ofs_y_r    <= '0;
      tile_col_r <= '0;
      tile_row_r <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      pixel_x_r  <= pixel_x_nxt;
      pixel_y_r  <= pixel_y_nxt;
      ofs_x_r    <= ofs_x_nxt;
      ofs_y_r    <= ofs_y_nxt;
      tile_col_r <= tile_col_nxt;
      tile_row_r <= tile_row_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r  <= tile_col_r;
      s1_row_r   <= tile_row_r;
      s1_start_r <= (ofs_x_r == '0) && (ofs_y_r == '0);
      s1_emit_r  <= tile_x_end && tile_y_end;
      s1_last_r  <= row_end && col_end;
      s1_min_r   <= pix_min;
      fwd_r      <= s1_valid_r && (s1_addr_r == tile_col_r);
      fwd_data_r <= s1_acc;
    end
  end

  // A tile update reads the entry on acceptance and writes it back in the next cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= col_mem[tile_col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      col_mem[s1_addr_r] <= s1_acc;
    end
  end

  always_comb begin
    if (s1_start_r) begin
      s1_prev = PIX_MAX;
    end else if (fwd_r) begin
      s1_prev = fwd_data_r;
    end else begin
      s1_prev = rd_data_r;
    end
    s1_acc = (s1_min_r < s1_prev) ? s1_min_r : s1_prev;
  end

  assign q_push    = s1_valid_r && s1_emit_r;
  assign q_pop     = out_valid && !out_stall;
  assign out_valid = q_cnt_r != '0;
  assign out_data  = queue_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (q_push && !q_pop) begin
        q_cnt_r <= q_cnt_r + QCNT_W'(1);
      end else if (q_pop && !q_push) begin
        q_cnt_r <= q_cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      queue_r[wr_ptr_r].tile_column <= s1_addr_r;
      queue_r[wr_ptr_r].tile_row    <= s1_row_r;
      queue_r[wr_ptr_r].min_value   <= s1_acc;
      queue_r[wr_ptr_r].frame_last  <= s1_last_r;
    end
  end

  `TDC_ASSERT_SAME(a_no_overflow, q_push && !q_pop, q_cnt_r != QCNT_W'(QDEPTH),
    "Result queue overflow.")
  `TDC_ASSERT_NEXT(a_accept_enters, accept, s1_valid_r,
    "Accepted pixel did not reach the update stage.")
  `TDC_ASSERT_SAME(a_last_emits, s1_valid_r && s1_last_r, s1_emit_r,
    "Frame end without a tile result.")
  `TDC_ASSERT_SAME(a_start_no_fwd_need, s1_valid_r && s1_start_r, s1_acc == s1_min_r,
    "Tile start did not begin from the pixel minimum.")

endmodule

`default_nettype wire
